>>> rtl/adcwin_pkg.sv
// Shared types, constants and helper functions for the ADC window statistics block.
package adcwin_pkg;

  localparam int WINDOW_LEN_DEF = 20;

  localparam int SAMPLE_W  = 12;
  localparam int SAMPLE_MAX = 4095;
  localparam int GAIN_W    = 17;
  localparam int OFFSET_W  = 21;
  localparam int REF_W     = 13;
  localparam int COUNT_W   = 13;
  localparam int MV_W      = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 21;

  // Shared multiplier: A operand, B operand, product
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 27;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // floor(x / 4095) for x < 2**26 as (x * MV_RECIP) >> MV_SH
  localparam int MV_SH = 38;
  localparam logic [MUL_B_W-1:0] MV_RECIP =
    MUL_B_W'(((64'd1 << MV_SH) + 64'd4094) / 64'd4095);

  localparam logic [GAIN_W-1:0]   MAX_GAIN_RST   = 17'd66847;
  localparam logic [OFFSET_W-1:0] MAX_OFFSET_RST = 21'sd236585;
  localparam logic [GAIN_W-1:0]   MIN_GAIN_RST   = 17'd67830;
  localparam logic [OFFSET_W-1:0] MIN_OFFSET_RST = -21'sd642253;
  localparam logic [GAIN_W-1:0]   AVG_GAIN_RST   = 17'd66847;
  localparam logic [OFFSET_W-1:0] AVG_OFFSET_RST = 21'sd166199;
  localparam logic [REF_W-1:0]    REF_MV_RST     = 13'd3300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_GAIN,
    REG_MAX_OFFSET,
    REG_MIN_GAIN,
    REG_MIN_OFFSET,
    REG_AVG_GAIN,
    REG_AVG_OFFSET,
    REG_REF_MV
  } reg_idx_t;

  localparam int STEP_W = 4;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT_IN,
    J_LOOP,
    J_END
  } jump_t;

  typedef enum logic [3:0] {
    M_NONE,
    M_SUM_RECIP,
    M_HI_GAIN,
    M_LO_GAIN,
    M_AVG_GAIN,
    M_CMAX_REF,
    M_CMIN_REF,
    M_CAVG_REF,
    M_P_RECIP
  } mul_sel_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_MEAN,
    W_CMAX,
    W_CMIN,
    W_CAVG,
    W_MVMAX,
    W_MVMIN,
    W_OUT
  } wb_t;

  typedef struct packed {
    jump_t             jmp;
    logic              clr;
    logic              rd;
    mul_sel_t          mul;
    wb_t               wb;
    logic [STEP_W-1:0] target;
  } uc_word_t;

  // Control store
  function automatic uc_word_t ucode_rom(input logic [STEP_W-1:0] step);
    uc_word_t w;
    w = '{jmp: J_NEXT, clr: 1'b0, rd: 1'b0, mul: M_NONE, wb: W_NONE, target: '0};
    unique case (step)
      4'd0:  begin w.jmp = J_WAIT_IN; w.clr = 1'b1; end
      4'd1:  begin w.jmp = J_LOOP; w.rd = 1'b1; w.target = 4'd1; end
      4'd2:  ; // drain last read
      4'd3:  w.mul = M_SUM_RECIP;
      4'd4:  begin w.wb = W_MEAN;  w.mul = M_HI_GAIN;  end
      4'd5:  begin w.wb = W_CMAX;  w.mul = M_LO_GAIN;  end
      4'd6:  begin w.wb = W_CMIN;  w.mul = M_AVG_GAIN; end
      4'd7:  begin w.wb = W_CAVG;  w.mul = M_CMAX_REF; end
      4'd8:  w.mul = M_P_RECIP;
      4'd9:  begin w.wb = W_MVMAX; w.mul = M_CMIN_REF; end
      4'd10: w.mul = M_P_RECIP;
      4'd11: begin w.wb = W_MVMIN; w.mul = M_CAVG_REF; end
      4'd12: w.mul = M_P_RECIP;
      4'd13: begin w.jmp = J_END; w.wb = W_OUT; w.target = 4'd0; end
      default: begin w.jmp = J_END; w.target = 4'd0; end
    endcase
    return w;
  endfunction

  // floor((value*gain + offset) / 65536), saturated to 0..8191
  function automatic logic [COUNT_W-1:0] calib(input logic [28:0] p,
                                               input logic [OFFSET_W-1:0] off);
    logic [30:0] t;
    logic [COUNT_W-1:0] r;
    t = {2'b00, p} + {{(31 - OFFSET_W){off[OFFSET_W-1]}}, off};
    if (t[30]) r = '0;
    else if (t[29]) r = '1;
    else r = t[28:16];
    return r;
  endfunction

  // Millivolt result from the reciprocal product, saturated to 14 bits
  function automatic logic [MV_W-1:0] mv_sat(input logic [PROD_W-1:0] p);
    logic [MV_W-1:0] r;
    if (p[PROD_W-1]) r = '1;
    else r = p[MV_SH +: MV_W];
    return r;
  endfunction

endpackage

>>> rtl/adc_window_min_max_avg.sv
// Top level: sliding-window min/max/mean with calibration, run by a microcoded sequencer.
//
//  channel | signals                          | dir | beat when
//  --------+----------------------------------+-----+----------------------
//  in      | in_valid in_ready sample         | in  | in_valid & in_ready
//  out     | out_valid out_ready min/max/avg  | out | out_valid & out_ready
//  cfg     | cfg_valid cfg_ready cfg_index    | in  | cfg_valid & cfg_ready
//          | cfg_data                         |     |
//
// Each item takes WINDOW_LEN reads of the window memory through its single read
// port, then ten steps on the one shared multiplier and a final load of the
// output register.
// Reset clears the per-entry valid bits at once; an invalid entry reads as zero.
// A new item is taken while a result still waits; the sequencer holds in its
// last step only while the previous result has not been taken.
module adc_window_min_max_avg #(
  parameter int WINDOW_LEN = adcwin_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [adcwin_pkg::SAMPLE_W-1:0]      sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [adcwin_pkg::COUNT_W-1:0]       min_count,
  output logic [adcwin_pkg::COUNT_W-1:0]       max_count,
  output logic [adcwin_pkg::COUNT_W-1:0]       avg_count,
  output logic [adcwin_pkg::MV_W-1:0]          min_mv,
  output logic [adcwin_pkg::MV_W-1:0]          max_mv,
  output logic [adcwin_pkg::MV_W-1:0]          avg_mv,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adcwin_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adcwin_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW       = adcwin_pkg::SAMPLE_W;
  localparam int CW       = adcwin_pkg::COUNT_W;
  localparam int VW       = adcwin_pkg::MV_W;
  localparam int AW       = adcwin_pkg::MUL_A_W;
  localparam int BW       = adcwin_pkg::MUL_B_W;
  localparam int PW       = adcwin_pkg::PROD_W;
  localparam int UW       = adcwin_pkg::STEP_W;
  localparam int IDX_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W    = $clog2(WINDOW_LEN * adcwin_pkg::SAMPLE_MAX + 1);
  localparam int RECIP_SH = SUM_W + $clog2(WINDOW_LEN);
  // floor(sum / WINDOW_LEN) as (sum * MEAN_RECIP) >> RECIP_SH
  localparam logic [RECIP_SH:0] MEAN_RECIP =
    (RECIP_SH + 1)'(((64'd1 << RECIP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

  // Configuration registers
  logic [adcwin_pkg::GAIN_W-1:0]   max_gain, min_gain, avg_gain;
  logic [adcwin_pkg::OFFSET_W-1:0] max_offset, min_offset, avg_offset;
  logic [adcwin_pkg::REF_W-1:0]    reference_mv;

  // Window memory and valid bits
  logic [SW-1:0]          win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  win_vld;
  logic [IDX_W-1:0]       write_slot;
  logic [IDX_W-1:0]       scan_idx;
  logic                   rd_pend;
  logic                   rd_ok;
  logic [SW-1:0]          rd_data;
  logic [SW-1:0]          rd_val;

  // Datapath registers
  logic [SW-1:0]    lo, hi, mean;
  logic [SUM_W-1:0] sum;
  logic [CW-1:0]    cmin, cmax, cavg;
  logic [VW-1:0]    mvmin, mvmax;
  logic [PW-1:0]    prod;
  logic [AW-1:0]    mul_a;
  logic [BW-1:0]    mul_b;

  // Sequencer
  logic [adcwin_pkg::STEP_W-1:0] upc, upc_next;
  adcwin_pkg::uc_word_t          uc;
  logic                          in_beat;
  logic                          out_blocked;
  logic                          out_load;

  assign uc          = adcwin_pkg::ucode_rom(upc);
  assign in_ready    = ~rst & (uc.jmp == adcwin_pkg::J_WAIT_IN);
  assign in_beat     = in_valid & in_ready;
  assign out_blocked = out_valid & ~out_ready;
  assign out_load    = (uc.wb == adcwin_pkg::W_OUT) & ~out_blocked;
  assign cfg_ready   = ~rst;

  always_comb begin
    unique case (uc.jmp)
      adcwin_pkg::J_NEXT:    upc_next = upc + UW'(1);
      adcwin_pkg::J_WAIT_IN: upc_next = in_beat ? upc + UW'(1) : upc;
      adcwin_pkg::J_LOOP:    upc_next = (scan_idx == LAST_IDX) ? upc + UW'(1) : uc.target;
      adcwin_pkg::J_END:     upc_next = out_blocked ? upc : uc.target;
      default:               upc_next = uc.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= '0;
    end else begin
      upc <= upc_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gain     <= adcwin_pkg::MAX_GAIN_RST;
      max_offset   <= adcwin_pkg::MAX_OFFSET_RST;
      min_gain     <= adcwin_pkg::MIN_GAIN_RST;
      min_offset   <= adcwin_pkg::MIN_OFFSET_RST;
      avg_gain     <= adcwin_pkg::AVG_GAIN_RST;
      avg_offset   <= adcwin_pkg::AVG_OFFSET_RST;
      reference_mv <= adcwin_pkg::REF_MV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adcwin_pkg::REG_MAX_GAIN:   max_gain     <= cfg_data[adcwin_pkg::GAIN_W-1:0];
        adcwin_pkg::REG_MAX_OFFSET: max_offset   <= cfg_data;
        adcwin_pkg::REG_MIN_GAIN:   min_gain     <= cfg_data[adcwin_pkg::GAIN_W-1:0];
        adcwin_pkg::REG_MIN_OFFSET: min_offset   <= cfg_data;
        adcwin_pkg::REG_AVG_GAIN:   avg_gain     <= cfg_data[adcwin_pkg::GAIN_W-1:0];
        adcwin_pkg::REG_AVG_OFFSET: avg_offset   <= cfg_data;
        adcwin_pkg::REG_REF_MV:     reference_mv <= cfg_data[adcwin_pkg::REF_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Window memory: write on input beat, registered read during the scan
  always_ff @(posedge clk) begin
    if (in_beat) begin
      win_mem[write_slot] <= sample;
    end
    if (uc.rd) begin
      rd_data <= win_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld    <= '0;
      write_slot <= '0;
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
      rd_ok      <= 1'b0;
    end else begin
      rd_pend <= uc.rd;
      if (uc.rd) begin
        rd_ok    <= win_vld[scan_idx];
        scan_idx <= scan_idx + IDX_W'(1);
      end else if (uc.clr) begin
        scan_idx <= '0;
      end
      if (in_beat) begin
        win_vld[write_slot] <= 1'b1;
        write_slot <= (write_slot == LAST_IDX) ? '0 : write_slot + IDX_W'(1);
      end
    end
  end

  assign rd_val = rd_ok ? rd_data : '0;

  // Scan accumulate
  always_ff @(posedge clk) begin
    if (uc.clr) begin
      lo  <= '1;
      hi  <= '0;
      sum <= '0;
    end else if (rd_pend) begin
      if (rd_val < lo) lo <= rd_val;
      if (rd_val > hi) hi <= rd_val;
      sum <= sum + SUM_W'(rd_val);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (uc.mul)
      adcwin_pkg::M_SUM_RECIP: begin mul_a = AW'(sum);  mul_b = BW'(MEAN_RECIP);   end
      adcwin_pkg::M_HI_GAIN:   begin mul_a = AW'(hi);   mul_b = BW'(max_gain);     end
      adcwin_pkg::M_LO_GAIN:   begin mul_a = AW'(lo);   mul_b = BW'(min_gain);     end
      adcwin_pkg::M_AVG_GAIN:  begin mul_a = AW'(mean); mul_b = BW'(avg_gain);     end
      adcwin_pkg::M_CMAX_REF:  begin mul_a = AW'(cmax); mul_b = BW'(reference_mv); end
      adcwin_pkg::M_CMIN_REF:  begin mul_a = AW'(cmin); mul_b = BW'(reference_mv); end
      adcwin_pkg::M_CAVG_REF:  begin mul_a = AW'(cavg); mul_b = BW'(reference_mv); end
      adcwin_pkg::M_P_RECIP:   begin mul_a = prod[AW-1:0]; mul_b = adcwin_pkg::MV_RECIP; end
      default:                 begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.mul != adcwin_pkg::M_NONE) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
  end

  // Write-back of the previous product
  always_ff @(posedge clk) begin
    unique case (uc.wb)
      adcwin_pkg::W_MEAN:  mean  <= prod[RECIP_SH +: SW];
      adcwin_pkg::W_CMAX:  cmax  <= adcwin_pkg::calib(prod[28:0], max_offset);
      adcwin_pkg::W_CMIN:  cmin  <= adcwin_pkg::calib(prod[28:0], min_offset);
      adcwin_pkg::W_CAVG:  cavg  <= adcwin_pkg::calib(prod[28:0], avg_offset);
      adcwin_pkg::W_MVMAX: mvmax <= adcwin_pkg::mv_sat(prod);
      adcwin_pkg::W_MVMIN: mvmin <= adcwin_pkg::mv_sat(prod);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      min_count <= cmin;
      max_count <= cmax;
      avg_count <= cavg;
      min_mv    <= mvmin;
      max_mv    <= mvmax;
      avg_mv    <= adcwin_pkg::mv_sat(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the ADC window min/max/mean statistics block.
module testbench;

  localparam int WIN           = adcwin_pkg::WINDOW_LEN_DEF;
  localparam int SW            = adcwin_pkg::SAMPLE_W;
  localparam int CW            = adcwin_pkg::COUNT_W;
  localparam int VW            = adcwin_pkg::MV_W;
  localparam int GW            = adcwin_pkg::GAIN_W;
  localparam int OW            = adcwin_pkg::OFFSET_W;
  localparam int RW            = adcwin_pkg::REF_W;
  localparam int IW            = adcwin_pkg::CFG_IDX_W;
  localparam int DW            = adcwin_pkg::CFG_DATA_W;
  localparam int COUNT_TOP     = 8191;
  localparam int MV_TOP        = 16383;
  localparam int FULL_SCALE    = 4095;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 153;
  localparam int IDLE_PCT      = 23;
  localparam logic [IW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CW-1:0] min_count;
    logic [CW-1:0] max_count;
    logic [CW-1:0] avg_count;
    logic [VW-1:0] min_mv;
    logic [VW-1:0] max_mv;
    logic [VW-1:0] avg_mv;
  } stats_t;

  class stats_board;
    logic [SW-1:0]        window [WIN];
    int                   slot;
    logic [GW-1:0]        max_gain, min_gain, avg_gain;
    logic signed [OW-1:0] max_offset, min_offset, avg_offset;
    logic [RW-1:0]        ref_mv;
    stats_t               expected_stats [$];
    int                   errors;

    function new();
      foreach (window[i]) window[i] = '0;
      slot       = 0;
      errors     = 0;
      max_gain   = adcwin_pkg::MAX_GAIN_RST;
      max_offset = adcwin_pkg::MAX_OFFSET_RST;
      min_gain   = adcwin_pkg::MIN_GAIN_RST;
      min_offset = adcwin_pkg::MIN_OFFSET_RST;
      avg_gain   = adcwin_pkg::AVG_GAIN_RST;
      avg_offset = adcwin_pkg::AVG_OFFSET_RST;
      ref_mv     = adcwin_pkg::REF_MV_RST;
    endfunction

    function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
      case (idx)
        adcwin_pkg::REG_MAX_GAIN:   max_gain   = data[GW-1:0];
        adcwin_pkg::REG_MAX_OFFSET: max_offset = data[OW-1:0];
        adcwin_pkg::REG_MIN_GAIN:   min_gain   = data[GW-1:0];
        adcwin_pkg::REG_MIN_OFFSET: min_offset = data[OW-1:0];
        adcwin_pkg::REG_AVG_GAIN:   avg_gain   = data[GW-1:0];
        adcwin_pkg::REG_AVG_OFFSET: avg_offset = data[OW-1:0];
        adcwin_pkg::REG_REF_MV:     ref_mv     = data[RW-1:0];
        default: ;
      endcase
    endfunction

    // floor((v * gain + offset) / 2^16), clamped to the count range
    function int unsigned apply_cal(int unsigned v, logic [GW-1:0] g,
                                    logic signed [OW-1:0] o);
      longint t;
      longint q;
      t = longint'(v) * longint'(g) + longint'(o);
      q = t >>> 16;
      if (q < 0) return 0;
      if (q > COUNT_TOP) return COUNT_TOP;
      return int'(q);
    endfunction

    function int unsigned count_to_mv(int unsigned c);
      longint m;
      m = longint'(c) * longint'(ref_mv) / FULL_SCALE;
      if (m > MV_TOP) m = MV_TOP;
      return int'(m);
    endfunction

    function void predict_stats(logic [SW-1:0] s);
      int unsigned lo, hi, sum, mean;
      stats_t      r;
      window[slot] = s;
      slot = (slot + 1) % WIN;
      lo  = 32'(window[0]);
      hi  = 32'(window[0]);
      sum = 0;
      foreach (window[i]) begin
        int unsigned w;
        w = 32'(window[i]);
        if (w < lo) lo = w;
        if (w > hi) hi = w;
        sum += w;
      end
      mean = sum / WIN;
      r.min_count = CW'(apply_cal(lo, min_gain, min_offset));
      r.max_count = CW'(apply_cal(hi, max_gain, max_offset));
      r.avg_count = CW'(apply_cal(mean, avg_gain, avg_offset));
      r.min_mv    = VW'(count_to_mv(32'(r.min_count)));
      r.max_mv    = VW'(count_to_mv(32'(r.max_count)));
      r.avg_mv    = VW'(count_to_mv(32'(r.avg_count)));
      expected_stats.push_back(r);
    endfunction

    function void diff(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check(stats_t got);
      stats_t want;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got %h", $time, got);
        return;
      end
      want = expected_stats.pop_front();
      diff("min_count", 32'(want.min_count), 32'(got.min_count));
      diff("max_count", 32'(want.max_count), 32'(got.max_count));
      diff("avg_count", 32'(want.avg_count), 32'(got.avg_count));
      diff("min_mv", 32'(want.min_mv), 32'(got.min_mv));
      diff("max_mv", 32'(want.max_mv), 32'(got.max_mv));
      diff("avg_mv", 32'(want.avg_mv), 32'(got.avg_mv));
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [SW-1:0] sample;
  logic          out_valid;
  logic          out_ready;
  logic [CW-1:0] min_count, max_count, avg_count;
  logic [VW-1:0] min_mv, max_mv, avg_mv;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  stats_board board;
  stats_t     seen;
  bit         calm;
  bit         hold_request;
  int         hold_left;

  adc_window_min_max_avg dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .min_count(min_count), .max_count(max_count), .avg_count(avg_count),
    .min_mv(min_mv), .max_mv(max_mv), .avg_mv(avg_mv),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = '{min_count: min_count, max_count: max_count, avg_count: avg_count,
                 min_mv: min_mv, max_mv: max_mv, avg_mv: avg_mv};
        board.check(seen);
      end
      if (in_valid && in_ready) board.predict_stats(sample);
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_sample(input logic [SW-1:0] s);
    sample   <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic cfg_write(input logic [IW-1:0] idx, input logic [DW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [DW-1:0] cv [7]);
    for (int r = adcwin_pkg::REG_MAX_GAIN; r <= adcwin_pkg::REG_REF_MV; r++) begin
      cfg_write(IW'(r), cv[r]);
    end
    // an out-of-range index must leave every register alone
    cfg_write(REG_UNUSED, DW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every result, then let the sequencer go quiet
  task automatic settle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (board.expected_stats.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [DW-1:0] cv [7];
    logic [SW-1:0] first_set [10];
    logic [SW-1:0] s;
    int            v;
    int            base;

    board        = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset calibration; the zero-filled window drives the minimum negative
    first_set = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001,
                  12'hFFE, 12'h800, 12'hFFF, 12'h000, 12'h7FF};
    foreach (first_set[i]) send_sample(first_set[i]);
    settle();

    // top of every register, with extra high bits on the narrow ones:
    // the max count clips high and its millivolt value clips too
    cv = '{21'h1FFFFF, 21'h0FFFFF, 21'h1FFFFF, 21'h0FFFFF, 21'h1FFFFF, 21'h0FFFFF, 21'h1FFFFF};
    program_regs(cv);
    repeat (6) send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h800);
    settle();

    // zero gains and most negative offsets: everything floors to zero
    cv = '{21'h000000, 21'h100000, 21'h000000, 21'h100000, 21'h000000, 21'h100000, 21'h000000};
    program_regs(cv);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h064);
    send_sample(12'hFFF);
    send_sample(12'h555);
    send_sample(12'hAAA);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(1)) begin
        for (int r = adcwin_pkg::REG_MAX_GAIN; r <= adcwin_pkg::REG_REF_MV; r++) begin
          cv[r] = DW'($urandom);
        end
      end else begin
        cv[adcwin_pkg::REG_MAX_GAIN]   = DW'($urandom_range(60000, 72000));
        cv[adcwin_pkg::REG_MIN_GAIN]   = DW'($urandom_range(60000, 72000));
        cv[adcwin_pkg::REG_AVG_GAIN]   = DW'($urandom_range(60000, 72000));
        cv[adcwin_pkg::REG_MAX_OFFSET] = DW'(int'($urandom_range(0, 600000)) - 300000);
        cv[adcwin_pkg::REG_MIN_OFFSET] = DW'(int'($urandom_range(0, 600000)) - 300000);
        cv[adcwin_pkg::REG_AVG_OFFSET] = DW'(int'($urandom_range(0, 600000)) - 300000);
        cv[adcwin_pkg::REG_REF_MV]     = DW'($urandom_range(0, 5000));
      end
      program_regs(cv);
      calm = (p == 5);
      // stall the result side long enough to back up the input
      if (p == 3) hold_request = 1'b1;
      base = $urandom_range(0, 4095);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case (p % 3)
          0: s = SW'($urandom_range(0, 4095));
          1: begin
            if (i % 25 == 0) base = $urandom_range(0, 4095);
            v = base + int'($urandom_range(0, 62)) - 31;
            if (v < 0) v = 0;
            if (v > adcwin_pkg::SAMPLE_MAX) v = adcwin_pkg::SAMPLE_MAX;
            s = SW'(v);
          end
          default: begin
            if ($urandom_range(9) == 0) s = $urandom_range(1) ? 12'hFFF : 12'h000;
            else s = SW'($urandom);
          end
        endcase
        send_sample(s);
      end
      settle();
      calm = 1'b0;
    end

    if (board.expected_stats.size() != 0) begin
      board.errors += board.expected_stats.size();
      $display("%0t: %0d results never arrived", $time, board.expected_stats.size());
    end
    if (board.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
